// ----- rtl/lct_pkg.sv -----
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants of the lockbox countdown timer.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int unsigned SecW   = 19;
  localparam int unsigned MsW    = 16;
  localparam int unsigned StepW  = 12;
  localparam int unsigned MinW   = 13;
  localparam int unsigned HourW  = 7;
  localparam int unsigned HhmmW  = 14;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [SecW-1:0] MAX_SECONDS = 19'd359999;
  localparam logic [MsW-1:0]  MS_SAT      = 16'hFFFF;

  // floor(x / 60) as (x * recip) >> shift, exact over the value range
  localparam logic [19:0] SEC_TO_MIN_MUL = 20'd559241;
  localparam int unsigned SecToMinShift  = 25;
  localparam logic [14:0] MIN_TO_HOUR_MUL = 15'd17477;
  localparam int unsigned MinToHourShift  = 20;

  localparam logic [StepW-1:0] RST_SHORT_STEP = 12'd60;
  localparam logic [StepW-1:0] RST_LONG_STEP  = 12'd300;
  localparam logic [MsW-1:0]   RST_SHORT_MS   = 16'd500;
  localparam logic [MsW-1:0]   RST_REPEAT_MS  = 16'd500;
  localparam logic [MsW-1:0]   RST_TPS        = 16'd1000;

  typedef enum logic [2:0] {
    REG_SHORT_PRESS_MS   = 3'd0,
    REG_REPEAT_MS        = 3'd1,
    REG_TICKS_PER_SECOND = 3'd2,
    REG_SHORT_STEP       = 3'd3,
    REG_LONG_STEP        = 3'd4
  } lct_reg_e;

  typedef struct packed {
    logic [MsW-1:0]   short_press_ms;
    logic [MsW-1:0]   repeat_ms;
    logic [MsW-1:0]   ticks_per_second;
    logic [StepW-1:0] short_step_seconds;
    logic [StepW-1:0] long_step_seconds;
  } lct_cfg_t;

  typedef struct packed {
    logic            locked;
    logic [SecW-1:0] seconds;
  } lct_res_t;

endpackage

// ----- rtl/lct_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lct_cfg_regs
// APB register bank holding the timer settings.
// ----------------------------------------------------------------------------
module lct_cfg_regs import lct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output lct_cfg_t         cfg_o
);

  lct_cfg_t cfg_q, cfg_d;
  lct_reg_e idx;
  logic     wr_en;

  assign idx    = lct_reg_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_SHORT_PRESS_MS:   cfg_d.short_press_ms     = pwdata[MsW-1:0];
        REG_REPEAT_MS:        cfg_d.repeat_ms          = pwdata[MsW-1:0];
        REG_TICKS_PER_SECOND: cfg_d.ticks_per_second   = pwdata[MsW-1:0];
        REG_SHORT_STEP:       cfg_d.short_step_seconds = pwdata[StepW-1:0];
        REG_LONG_STEP:        cfg_d.long_step_seconds  = pwdata[StepW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SHORT_PRESS_MS:   prdata = DataW'(cfg_q.short_press_ms);
      REG_REPEAT_MS:        prdata = DataW'(cfg_q.repeat_ms);
      REG_TICKS_PER_SECOND: prdata = DataW'(cfg_q.ticks_per_second);
      REG_SHORT_STEP:       prdata = DataW'(cfg_q.short_step_seconds);
      REG_LONG_STEP:        prdata = DataW'(cfg_q.long_step_seconds);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_press_ms     <= RST_SHORT_MS;
      cfg_q.repeat_ms          <= RST_REPEAT_MS;
      cfg_q.ticks_per_second   <= RST_TPS;
      cfg_q.short_step_seconds <= RST_SHORT_STEP;
      cfg_q.long_step_seconds  <= RST_LONG_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/lct_core.sv -----
// ----------------------------------------------------------------------------
// lct_core
// Per-tick state update: button handling in set mode, countdown when locked.
// ----------------------------------------------------------------------------
module lct_core import lct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     start_pressed_i,
  input  logic     set_pressed_i,
  input  lct_cfg_t cfg_i,
  output lct_res_t res_o
);

  logic            counting_q, counting_d;
  logic [SecW-1:0] secs_q, secs_d;
  logic            set_was_q, set_was_d;
  logic [MsW-1:0]  hold_q, hold_d;
  logic [MsW-1:0]  pause_q, pause_d;
  logic [MsW-1:0]  sticks_q, sticks_d;

  logic [MsW-1:0]   hold_inc;
  logic [MsW:0]     sticks_inc;
  logic             add_en;
  logic [StepW-1:0] step;
  logic [SecW:0]    sum;

  assign hold_inc   = (hold_q != MS_SAT) ? hold_q + 16'd1 : hold_q;
  assign sticks_inc = {1'b0, sticks_q} + 17'd1;
  assign sum        = {1'b0, secs_q} + (SecW+1)'(step);

  always_comb begin
    counting_d = counting_q;
    secs_d     = secs_q;
    set_was_d  = set_was_q;
    hold_d     = hold_q;
    pause_d    = pause_q;
    sticks_d   = sticks_q;
    add_en     = 1'b0;
    step       = cfg_i.long_step_seconds;
    if (!counting_q) begin
      if (pause_q != '0) begin
        pause_d = pause_q - 16'd1;
        if (set_was_q) begin
          hold_d = hold_inc;
        end
      end else if (start_pressed_i) begin
        counting_d = 1'b1;
        sticks_d   = '0;
      end else if (set_pressed_i != set_was_q) begin
        hold_d    = '0;
        set_was_d = set_pressed_i;
        if (set_pressed_i) begin
          add_en = 1'b1;
          step   = cfg_i.short_step_seconds;
        end
      end else if (set_pressed_i) begin
        hold_d = hold_inc;
        if (hold_inc > cfg_i.short_press_ms) begin
          add_en  = 1'b1;
          pause_d = cfg_i.repeat_ms;
        end
      end
    end else begin
      if (secs_q != '0) begin
        if (sticks_inc >= {1'b0, cfg_i.ticks_per_second}) begin
          secs_d   = secs_q - 19'd1;
          sticks_d = '0;
        end else begin
          sticks_d = sticks_inc[MsW-1:0];
        end
      end else begin
        counting_d = 1'b0;
        sticks_d   = '0;
      end
    end
    if (add_en) begin
      secs_d = (sum > {1'b0, MAX_SECONDS}) ? MAX_SECONDS : sum[SecW-1:0];
    end
  end

  assign res_o.locked  = counting_d;
  assign res_o.seconds = secs_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counting_q <= 1'b0;
      secs_q     <= '0;
      set_was_q  <= 1'b0;
      hold_q     <= '0;
      pause_q    <= '0;
      sticks_q   <= '0;
    end else if (adv_i) begin
      counting_q <= counting_d;
      secs_q     <= secs_d;
      set_was_q  <= set_was_d;
      hold_q     <= hold_d;
      pause_q    <= pause_d;
      sticks_q   <= sticks_d;
    end
  end

endmodule

// ----- rtl/lct_hhmm_pipe.sv -----
// ----------------------------------------------------------------------------
// lct_hhmm_pipe
// Result pipeline: seconds to minutes, minutes to hours, HHMM assembly.
// ----------------------------------------------------------------------------
module lct_hhmm_pipe import lct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lct_res_t         res_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             locked_o,
  output logic [SecW-1:0]  remaining_seconds_o,
  output logic [HhmmW-1:0] display_hhmm_o
);

  logic             v1_q, v2_q, v3_q, vo_q;
  logic             en1, en2, en3, eno;
  lct_res_t         r1_q, r2_q, r3_q, ro_q;
  logic [MinW-1:0]  mt2_q, mt3_q;
  logic [HourW-1:0] h3_q;
  logic [HhmmW-1:0] hhmm_q;

  logic [SecW+19:0] min_prod;
  logic [MinW+14:0] hour_prod;
  logic [11:0]      h40;

  assign eno = !vo_q || out_ready_i;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign min_prod  = (SecW+20)'(r1_q.seconds) * (SecW+20)'(SEC_TO_MIN_MUL);
  assign hour_prod = (MinW+15)'(mt2_q) * (MinW+15)'(MIN_TO_HOUR_MUL);
  assign h40       = 12'({h3_q, 5'b0}) + 12'({h3_q, 3'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      r1_q <= res_i;
    end
    if (en2 && v1_q) begin
      r2_q  <= r1_q;
      mt2_q <= min_prod[SecToMinShift +: MinW];
    end
    if (en3 && v2_q) begin
      r3_q  <= r2_q;
      mt3_q <= mt2_q;
      h3_q  <= hour_prod[MinToHourShift +: HourW];
    end
    if (eno && v3_q) begin
      ro_q   <= r3_q;
      hhmm_q <= HhmmW'(mt3_q) + HhmmW'(h40);
    end
  end

  assign out_valid_o         = vo_q;
  assign locked_o            = ro_q.locked;
  assign remaining_seconds_o = ro_q.seconds;
  assign display_hhmm_o      = hhmm_q;

endmodule

// ----- rtl/lockbox_countdown_timer.sv -----
// ----------------------------------------------------------------------------
// lockbox_countdown_timer
// Millisecond-tick lockbox timer: time setting, lock, countdown, HHMM view.
// ----------------------------------------------------------------------------
// channel  | signals                                         | direction
// tick     | in_valid_i/in_ready_o, start_pressed_i, set_... | in
// result   | out_valid_o/out_ready_i, locked_o, remaining... | out
// config   | psel/penable/pwrite/paddr/pwdata/prdata/pready  | APB
//
// One tick per cycle sustained unless a result-side stall fills the pipeline.
// The timer state updates in the transfer cycle; three more registered
// stages convert seconds to HHMM with two reciprocal multipliers.
// Reset loads the default settings and clears the timer to set mode, 0 s.
// A result-side stall fills the four stages, then drops in_ready_o.
// ----------------------------------------------------------------------------
module lockbox_countdown_timer import lct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             start_pressed_i,
  input  logic             set_pressed_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             locked_o,
  output logic [SecW-1:0]  remaining_seconds_o,
  output logic [HhmmW-1:0] display_hhmm_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  lct_cfg_t cfg;
  lct_res_t res;
  logic     adv;

  assign adv = in_valid_i & in_ready_o;

  lct_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lct_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .start_pressed_i (start_pressed_i),
    .set_pressed_i   (set_pressed_i),
    .cfg_i           (cfg),
    .res_o           (res)
  );

  lct_hhmm_pipe u_pipe (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .res_i               (res),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .locked_o            (locked_o),
    .remaining_seconds_o (remaining_seconds_o),
    .display_hhmm_o      (display_hhmm_o)
  );

endmodule

// ----- rtl/lct_checker.sv -----
// ----------------------------------------------------------------------------
// lct_checker
// Port-level checks of the lockbox countdown timer, bound to the top level.
// ----------------------------------------------------------------------------
module lct_checker import lct_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [SecW-1:0]  remaining_seconds_o,
  input logic [HhmmW-1:0] display_hhmm_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_seconds_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> remaining_seconds_o <= MAX_SECONDS)
    else $error("remaining seconds out of range");

  a_hhmm_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && remaining_seconds_o < 19'd60 |-> display_hhmm_o == '0)
    else $error("display not zero below one minute");

endmodule

bind lockbox_countdown_timer lct_checker u_lct_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the lockbox countdown timer.
// A tick driver feeds button levels over the valid/ready tick channel while
// a behavioral copy of the timer predicts the lock state, the seconds and
// the HHMM value of every result. Each result transfer is checked against
// the oldest prediction. The settings are written and read back over the
// APB port whenever the pipeline is empty. The tests cover reset values,
// directed corner cases, random press/hold/start/countdown sequences under
// sender gaps and receiver stalls, the 16-bit extremes, and saturation.
// ----------------------------------------------------------------------------
module tb;
  import lct_pkg::*;

  localparam int unsigned WatchLimit    = 4000;
  localparam int unsigned ResultLatency = 4;
  localparam int unsigned MaxShown      = 40;
  localparam int unsigned SecsPerHour   = 3600;
  localparam int unsigned SecsPerMin    = 60;
  localparam int unsigned HourWeight    = 100;

  typedef struct packed {
    logic             locked;
    logic [SecW-1:0]  seconds;
    logic [HhmmW-1:0] hhmm;
  } tick_view_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             start_pressed_i = 1'b0;
  logic             set_pressed_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             locked_o;
  logic [SecW-1:0]  remaining_seconds_o;
  logic [HhmmW-1:0] display_hhmm_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  lct_cfg_t        cfg_q;
  logic            counting_q;
  logic [SecW-1:0] secs_q;
  logic            set_seen_q;
  int unsigned     hold_q;
  int unsigned     pause_q;
  int unsigned     sec_ticks_q;

  tick_view_t  pending_views[$];
  int unsigned errors = 0;
  int unsigned shown = 0;
  int unsigned ticks_sent = 0;
  int unsigned views_checked = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  lockbox_countdown_timer dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .start_pressed_i,
    .set_pressed_i,
    .out_valid_o,
    .out_ready_i,
    .locked_o,
    .remaining_seconds_o,
    .display_hhmm_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (shown < MaxShown) begin
      shown++;
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  function automatic void add_seconds(int unsigned step);
    int unsigned total;
    total = secs_q + step;
    secs_q = (total > MAX_SECONDS) ? MAX_SECONDS : SecW'(total);
  endfunction

  function automatic tick_view_t timer_step(logic start, logic setb);
    tick_view_t  view;
    int unsigned hours;
    int unsigned minutes;
    if (!counting_q) begin
      if (pause_q != 0) begin
        pause_q--;
        if (set_seen_q && hold_q < MS_SAT) hold_q++;
      end else if (start) begin
        counting_q = 1'b1;
        sec_ticks_q = 0;
      end else begin
        if (setb != set_seen_q) begin
          if (setb) add_seconds(32'(cfg_q.short_step_seconds));
          hold_q = 0;
          set_seen_q = setb;
        end else if (setb && hold_q < MS_SAT) begin
          hold_q++;
        end
        if (setb && hold_q > cfg_q.short_press_ms) begin
          add_seconds(32'(cfg_q.long_step_seconds));
          pause_q = 32'(cfg_q.repeat_ms);
        end
      end
    end else if (secs_q != 0) begin
      sec_ticks_q++;
      if (sec_ticks_q >= cfg_q.ticks_per_second) begin
        secs_q--;
        sec_ticks_q = 0;
      end
    end else begin
      counting_q = 1'b0;
      sec_ticks_q = 0;
    end
    hours = secs_q / SecsPerHour;
    minutes = (secs_q % SecsPerHour) / SecsPerMin;
    view.locked = counting_q;
    view.seconds = secs_q;
    view.hhmm = HhmmW'(hours * HourWeight + minutes);
    return view;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_views.push_back(timer_step(start_pressed_i, set_pressed_i));
    end
  end

  always @(posedge clk_i) begin : check_results
    tick_view_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      views_checked++;
      if (pending_views.size() == 0) begin
        report_mismatch("result with nothing pending, seconds",
                        32'(remaining_seconds_o), 0);
      end else begin
        want = pending_views.pop_front();
        if (locked_o !== want.locked)
          report_mismatch("locked", 32'(locked_o), 32'(want.locked));
        if (remaining_seconds_o !== want.seconds)
          report_mismatch("remaining seconds", 32'(remaining_seconds_o),
                          32'(want.seconds));
        if (display_hhmm_o !== want.hhmm)
          report_mismatch("display hhmm", 32'(display_hhmm_o), 32'(want.hhmm));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_tick(input logic start, input logic setb);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    start_pressed_i <= start;
    set_pressed_i <= setb;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_views.size() != 0);
  endtask

  task automatic run_countdown();
    while (counting_q) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic apb_access(input logic write, input lct_reg_e idx,
                            input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= AddrW'(4 * int'(idx));
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] reg_value(lct_reg_e idx);
    case (idx)
      REG_SHORT_PRESS_MS:   return DataW'(cfg_q.short_press_ms);
      REG_REPEAT_MS:        return DataW'(cfg_q.repeat_ms);
      REG_TICKS_PER_SECOND: return DataW'(cfg_q.ticks_per_second);
      REG_SHORT_STEP:       return DataW'(cfg_q.short_step_seconds);
      REG_LONG_STEP:        return DataW'(cfg_q.long_step_seconds);
      default:              return '0;
    endcase
  endfunction

  task automatic reg_check(input lct_reg_e idx);
    logic [DataW-1:0] readback;
    apb_access(1'b0, idx, '0, readback);
    if (readback !== reg_value(idx)) report_mismatch({"readback ", idx.name()},
                                                     readback, reg_value(idx));
  endtask

  task automatic reg_write(input lct_reg_e idx, input int unsigned value);
    logic [DataW-1:0] unused;
    apb_access(1'b1, idx, DataW'(value), unused);
    case (idx)
      REG_SHORT_PRESS_MS:   cfg_q.short_press_ms = MsW'(value);
      REG_REPEAT_MS:        cfg_q.repeat_ms = MsW'(value);
      REG_TICKS_PER_SECOND: cfg_q.ticks_per_second = MsW'(value);
      REG_SHORT_STEP:       cfg_q.short_step_seconds = StepW'(value);
      REG_LONG_STEP:        cfg_q.long_step_seconds = StepW'(value);
      default: ;
    endcase
    reg_check(idx);
  endtask

  task automatic set_config(input int unsigned short_ms, input int unsigned rep_ms,
                            input int unsigned tps, input int unsigned short_step,
                            input int unsigned long_step);
    reg_write(REG_SHORT_PRESS_MS, short_ms);
    reg_write(REG_REPEAT_MS, rep_ms);
    reg_write(REG_TICKS_PER_SECOND, tps);
    reg_write(REG_SHORT_STEP, short_step);
    reg_write(REG_LONG_STEP, long_step);
  endtask

  task automatic test_register_defaults();
    for (int i = REG_SHORT_PRESS_MS; i <= REG_LONG_STEP; i++) reg_check(lct_reg_e'(i));
  endtask

  task automatic test_register_extremes();
    set_config(65535, 65535, 65535, 4095, 4095);
    set_config(0, 0, 0, 0, 0);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(1, 2, 0, 1, 2);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    wait_results_done();
    set_config(0, 0, 1, 0, 1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    run_countdown();
    wait_results_done();
  endtask

  task automatic test_random_sequences(input int unsigned items, input int unsigned idle_pct,
                                       input int unsigned stall_pct);
    int unsigned start_count;
    int unsigned seq_count;
    set_config(($urandom_range(3) == 0) ? 65535 : $urandom_range(6), $urandom_range(6),
               $urandom_range(2), $urandom_range(8), $urandom_range(4));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start_count = ticks_sent;
    seq_count = 0;
    while (ticks_sent - start_count < items) begin
      if ($urandom_range(9) < 8) begin
        repeat ($urandom_range(1, 4)) begin
          repeat ($urandom_range(1, 12)) send_tick($urandom_range(19) == 0, 1'b1);
          repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0);
        end
        send_tick(1'b1, 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 10))
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      run_countdown();
      seq_count++;
      if (seq_count % 8 == 3 || $urandom_range(15) == 0) wait_results_done();
    end
    wait_results_done();
  endtask

  task automatic test_long_hold_extremes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(0, 40, 65535, 0, 1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    while (pause_q != 0) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    repeat (20) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    wait_results_done();
    reg_write(REG_TICKS_PER_SECOND, 1);
    run_countdown();
    wait_results_done();
  endtask

  task automatic test_saturation();
    send_idle_pct = 19;
    recv_stall_pct = 19;
    set_config(0, 0, 1, 3600, 3600);
    send_tick(1'b0, 1'b0);
    repeat (110) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    repeat (5) send_tick(1'b0, 1'($urandom_range(1)));
    wait_results_done();
  endtask

  initial begin
    cfg_q.short_press_ms = RST_SHORT_MS;
    cfg_q.repeat_ms = RST_REPEAT_MS;
    cfg_q.ticks_per_second = RST_TPS;
    cfg_q.short_step_seconds = RST_SHORT_STEP;
    cfg_q.long_step_seconds = RST_LONG_STEP;
    counting_q = 1'b0;
    secs_q = '0;
    set_seen_q = 1'b0;
    hold_q = 0;
    pause_q = 0;
    sec_ticks_q = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_register_defaults();
    test_register_extremes();
    test_directed();
    test_random_sequences(140, 0, 0);
    test_random_sequences(140, 60, 0);
    test_random_sequences(140, 0, 60);
    test_random_sequences(140, 19, 19);
    test_long_hold_extremes();
    test_saturation();
    repeat (ResultLatency + 4) @(negedge clk_i);
    if (pending_views.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_views.size());
    end
    $display("covered %0d tick transfers and %0d checked results", ticks_sent, views_checked);
    $display("register access, directed cases, random sequences, 16-bit extremes, saturation");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
